>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define LSR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// cond must never be true outside reset
`define LSR_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define LSR_ASSERT(label, clk, rst_n, prop)
`define LSR_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> design/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Types and constants shared by the lid servo toggle/ramp block.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int POS_W  = 15;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 2;
    localparam int STEP_W = 2;
    localparam int ADDR_W = 3;

    // config register indexes
    localparam logic [ADDR_W-1:0] CFG_OPEN_ANGLE  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_CLOSE_ANGLE = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_RAMP_STEP   = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_RELEASE_GAP = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_OPEN_HOLD   = 3'd4;

    // remote switch detector steps
    localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_ARMED = 2'd1;
    localparam logic [STEP_W-1:0] STEP_FIRE  = 2'd2;
    localparam logic [STEP_W-1:0] STEP_SPARE = 2'd3;

    localparam logic [CNT_W-1:0] PRESSES_TO_OPEN = 2'd2;
    localparam logic [CNT_W-1:0] PRESS_MAX       = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic              shots_nonzero;
        logic              aim_lock_active;
        logic              key_v;
        logic              key_e;
        logic              key_q;
        logic              key_x;
        logic              sw1_up;
        logic              sw2_mid;
        logic              key_mode;
        logic              sys_init;
    } t_tick;

    typedef struct packed {
        logic [POS_W-1:0]  open_angle;
        logic [POS_W-1:0]  close_angle;
        logic [POS_W-1:0]  ramp_step;
        logic [TIME_W-1:0] release_gap_ticks;
        logic [TIME_W-1:0] open_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] target;
        logic             clear_shots;
    } t_ctrl_res;

endpackage

>>> design/lsr_ctrl.sv
// ----------------------------------------------------------------------------
// lsr_ctrl
// Remote toggle detector, key-mode press/hold logic and lid target register.
// ----------------------------------------------------------------------------
module lsr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  lsr_pkg::t_tick     i_tick,
    input  lsr_pkg::t_cfg      i_cfg,
    output lsr_pkg::t_ctrl_res o_res,
    output logic [lsr_pkg::STEP_W-1:0] o_step
);

    logic [lsr_pkg::POS_W-1:0]  r_target, n_target;
    logic [lsr_pkg::STEP_W-1:0] r_step, n_step;
    logic                       r_key_open, n_key_open;
    logic                       r_x_rel, n_x_rel;
    logic [lsr_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_came_remote, n_came_remote;
    logic [lsr_pkg::TIME_W-1:0] r_last_press, n_last_press;
    logic [lsr_pkg::TIME_W-1:0] r_hold_start, n_hold_start;
    logic                       n_clear;
    logic [lsr_pkg::TIME_W-1:0] gap_elapsed;
    logic [lsr_pkg::TIME_W-1:0] hold_elapsed;

    assign gap_elapsed = i_tick.time_now - r_last_press;

    always_comb begin
        n_target      = r_target;
        n_step        = r_step;
        n_key_open    = r_key_open;
        n_x_rel       = r_x_rel;
        n_cnt         = r_cnt;
        n_came_remote = r_came_remote;
        n_last_press  = r_last_press;
        n_hold_start  = r_hold_start;
        n_clear       = 1'b0;
        hold_elapsed  = i_tick.time_now - r_hold_start;

        if (i_tick.sys_init) begin
            n_target = i_cfg.close_angle;
            n_x_rel  = 1'b1;
            n_cnt    = '0;
        end else begin
            // sw2 mid, then sw1 low, then sw1 high fires a toggle
            if (i_tick.sw2_mid) begin
                if (i_tick.sw1_up) begin
                    if (r_step == lsr_pkg::STEP_ARMED) begin
                        n_step = lsr_pkg::STEP_FIRE;
                    end else if (r_step == lsr_pkg::STEP_FIRE) begin
                        n_step = lsr_pkg::STEP_IDLE;
                    end
                end else begin
                    n_step = lsr_pkg::STEP_ARMED;
                end
            end else begin
                n_step = lsr_pkg::STEP_IDLE;
            end
            if (n_step == lsr_pkg::STEP_FIRE) begin
                n_target = (r_target == i_cfg.open_angle) ? i_cfg.close_angle
                                                          : i_cfg.open_angle;
            end

            if (i_tick.key_mode) begin
                if (r_came_remote) begin
                    n_key_open    = 1'b0;
                    n_target      = i_cfg.close_angle;
                    n_came_remote = 1'b0;
                end
                if (!n_key_open) begin
                    if (!i_tick.key_x) begin
                        n_x_rel = 1'b1;
                        if (gap_elapsed > i_cfg.release_gap_ticks) begin
                            n_cnt = '0;
                        end
                    end
                    if (i_tick.key_x && n_x_rel && !i_tick.aim_lock_active) begin
                        n_last_press = i_tick.time_now;
                        n_x_rel      = 1'b0;
                        if (n_cnt != lsr_pkg::PRESS_MAX) begin
                            n_cnt = n_cnt + 2'd1;
                        end
                    end
                    if (n_cnt >= lsr_pkg::PRESSES_TO_OPEN) begin
                        n_key_open   = 1'b1;
                        n_target     = i_cfg.open_angle;
                        n_clear      = i_tick.shots_nonzero;
                        n_hold_start = i_tick.time_now;
                    end else begin
                        n_target = i_cfg.close_angle;
                    end
                end else begin
                    // X released restarts the hold timer, so elapsed is zero
                    if (!i_tick.key_x) begin
                        n_x_rel      = 1'b1;
                        n_hold_start = i_tick.time_now;
                        hold_elapsed = '0;
                    end
                    if (hold_elapsed > i_cfg.open_hold_ticks || i_tick.key_q
                        || i_tick.key_e || i_tick.key_v) begin
                        n_key_open = 1'b0;
                    end else begin
                        n_target = i_cfg.open_angle;
                    end
                    n_cnt = '0;
                end
            end else begin
                n_key_open    = 1'b0;
                n_x_rel       = 1'b1;
                n_cnt         = '0;
                n_came_remote = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= '0;
            r_step        <= lsr_pkg::STEP_IDLE;
            r_key_open    <= 1'b0;
            r_x_rel       <= 1'b1;
            r_cnt         <= '0;
            r_came_remote <= 1'b1;
            r_last_press  <= '0;
            r_hold_start  <= '0;
        end else if (i_adv) begin
            r_target      <= n_target;
            r_step        <= n_step;
            r_key_open    <= n_key_open;
            r_x_rel       <= n_x_rel;
            r_cnt         <= n_cnt;
            r_came_remote <= n_came_remote;
            r_last_press  <= n_last_press;
            r_hold_start  <= n_hold_start;
        end
    end

    assign o_res.target      = n_target;
    assign o_res.clear_shots = n_clear;
    assign o_step            = r_step;

endmodule

>>> design/lsr_ramp.sv
// ----------------------------------------------------------------------------
// lsr_ramp
// Actual position register, stepped toward the target and clamped at it.
// ----------------------------------------------------------------------------
module lsr_ramp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_starting,
    input  logic [lsr_pkg::POS_W-1:0] i_close,
    input  logic [lsr_pkg::POS_W-1:0] i_target,
    input  logic [lsr_pkg::POS_W-1:0] i_step,
    output logic [lsr_pkg::POS_W-1:0] o_pos_next
);

    logic [lsr_pkg::POS_W-1:0] r_pos;
    logic [lsr_pkg::POS_W-1:0] base;
    logic [lsr_pkg::POS_W:0]   sum;
    logic [lsr_pkg::POS_W-1:0] diff;

    // starting snaps the position to closed before the ramp
    assign base = i_starting ? i_close : r_pos;
    assign sum  = {1'b0, base} + {1'b0, i_step};
    assign diff = base - i_target;

    always_comb begin
        if (base < i_target) begin
            o_pos_next = (sum > {1'b0, i_target}) ? i_target : sum[lsr_pkg::POS_W-1:0];
        end else if (base > i_target) begin
            o_pos_next = (diff < i_step) ? i_target : base - i_step;
        end else begin
            o_pos_next = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_adv) begin
            r_pos <= o_pos_next;
        end
    end

endmodule

>>> design/lid_servo_toggle_ramp.sv
// ----------------------------------------------------------------------------
// lid_servo_toggle_ramp
// Lid servo control: remote toggle / key-mode open-close and position ramp.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                       payload
//  s_axis    in    s_axis_tvalid / s_axis_tready   s_axis_tdata[47:0] control tick
//  m_axis    out   m_axis_tvalid / m_axis_tready   m_axis_tdata[23:0] servo result
//  cfg       in    i_cfg_valid / o_cfg_ready       i_cfg_addr, i_cfg_data
//
// One item per cycle sustained while m_axis_tready holds; an item held in the
// input register writes its result into the result register as it advances.
// The result register frees as it is taken, so an item enters while a result
// waits; only a stalled result plus a full input register lowers s_axis_tready.
// Reset is synchronous, active low; config writes are always taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lid_servo_toggle_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] sys_init [1] key_mode [2] sw2_mid [3] sw1_up [4] key_x
    // [5] key_q [6] key_e [7] key_v [8] aim_lock_active [9] shots_nonzero
    // [41:10] time_now [47:42] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [14:0] servo_pulse [15] target_open [16] lid_open [17] clear_shots
    // [23:18] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    lsr_pkg::t_tick             r_in;
    logic                       r_in_valid;
    lsr_pkg::t_cfg              r_cfg;
    logic                       r_out_valid;
    logic [23:0]                r_out;
    logic                       adv;
    lsr_pkg::t_ctrl_res         ctrl_res;
    logic [lsr_pkg::POS_W-1:0]  pos_next;
    logic [lsr_pkg::STEP_W-1:0] det_step;
    lsr_pkg::t_tick             tick_in;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign tick_in.sys_init        = s_axis_tdata[0];
    assign tick_in.key_mode        = s_axis_tdata[1];
    assign tick_in.sw2_mid         = s_axis_tdata[2];
    assign tick_in.sw1_up          = s_axis_tdata[3];
    assign tick_in.key_x           = s_axis_tdata[4];
    assign tick_in.key_q           = s_axis_tdata[5];
    assign tick_in.key_e           = s_axis_tdata[6];
    assign tick_in.key_v           = s_axis_tdata[7];
    assign tick_in.aim_lock_active = s_axis_tdata[8];
    assign tick_in.shots_nonzero   = s_axis_tdata[9];
    assign tick_in.time_now        = s_axis_tdata[41:10];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_angle        <= '0;
            r_cfg.close_angle       <= '0;
            r_cfg.ramp_step         <= 15'd100;
            r_cfg.release_gap_ticks <= 32'd200;
            r_cfg.open_hold_ticks   <= 32'd800;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                lsr_pkg::CFG_OPEN_ANGLE:  r_cfg.open_angle  <= i_cfg_data[14:0];
                lsr_pkg::CFG_CLOSE_ANGLE: r_cfg.close_angle <= i_cfg_data[14:0];
                lsr_pkg::CFG_RAMP_STEP:   r_cfg.ramp_step   <= i_cfg_data[14:0];
                lsr_pkg::CFG_RELEASE_GAP: r_cfg.release_gap_ticks <= i_cfg_data;
                lsr_pkg::CFG_OPEN_HOLD:   r_cfg.open_hold_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= tick_in;
        end
    end

    lsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tick  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (ctrl_res),
        .o_step  (det_step)
    );

    lsr_ramp u_ramp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_starting (r_in.sys_init),
        .i_close    (r_cfg.close_angle),
        .i_target   (ctrl_res.target),
        .i_step     (r_cfg.ramp_step),
        .o_pos_next (pos_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= {6'd0,
                      ctrl_res.clear_shots,
                      (pos_next == r_cfg.open_angle),
                      (ctrl_res.target == r_cfg.open_angle),
                      pos_next};
        end
    end

    // a shot-count clear only comes with an opening, so the target is open
    `LSR_ASSERT(a_clr_open, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[15])
    // detector never reaches the unused step from reset
    `LSR_ASSERT_NEVER(a_no_spare_step, i_clk, i_rst_n, det_step == lsr_pkg::STEP_SPARE)
    // full input register behind a stalled result must backpressure
    `LSR_ASSERT(a_bp, i_clk, i_rst_n, r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)

endmodule
